@@ sv/jetp_pkg.sv @@
// Shared types, constants and helper functions for the Julia escape-time pixel unit.
// Used by jetp_iter_unit, julia_escape_time_pixel_unit and the testbench; depends on nothing else.
package jetp_pkg;

   localparam int ITERATION_STAGES_DEFAULT = 64;
   localparam int FRACTION_BITS_DEFAULT    = 28;

   localparam int COORD_WIDTH     = 32;
   localparam int PIXEL_WIDTH     = 10;
   localparam int STEP_WIDTH      = 31;
   localparam int ITER_WIDTH      = 7;
   localparam int COLOR_WIDTH     = 24;
   localparam int INDEX_WIDTH     = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;
   localparam int WIDE_WIDTH      = 2 * COORD_WIDTH + 1;

   localparam int PALETTE_MODULUS = 50;
   localparam int PALETTE_SIZE    = 55;

   localparam logic [COLOR_WIDTH-1:0] INSIDE_COLOR = 24'h000000;

   // Register map
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_ORIGIN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_ORIGIN = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_X_STEP   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_Y_STEP   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_C_REAL   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_C_IMAG   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_ITER = 3'd6;

   localparam logic signed [COORD_WIDTH-1:0] X_ORIGIN_RESET = -32'sd536870912;
   localparam logic signed [COORD_WIDTH-1:0] Y_ORIGIN_RESET = -32'sd536870912;
   localparam logic [STEP_WIDTH-1:0]         X_STEP_RESET   = 31'd1048576;
   localparam logic [STEP_WIDTH-1:0]         Y_STEP_RESET   = 31'd1048576;
   localparam logic signed [COORD_WIDTH-1:0] C_REAL_RESET   = 32'sd0;
   localparam logic signed [COORD_WIDTH-1:0] C_IMAG_RESET   = 32'sd0;
   localparam logic [ITER_WIDTH-1:0]         MAX_ITER_RESET = 7'd55;

   localparam logic signed [WIDE_WIDTH-1:0] COORD_MAX = 65'sd2147483647;
   localparam logic signed [WIDE_WIDTH-1:0] COORD_MIN = -65'sd2147483648;

   localparam logic [COLOR_WIDTH-1:0] PALETTE_ROM [PALETTE_SIZE] = '{
      24'h2C1014, 24'h251016, 24'h1F1118, 24'h191119, 24'h140F1A, 24'h100D26, 24'h0D0A2D,
      24'h0A0733, 24'h07053A, 24'h040249, 24'h020352, 24'h01055C, 24'h000766, 24'h06227E,
      24'h0C2C8A, 24'h11388C, 24'h18459C, 24'h1F52B1, 24'h2A60B7, 24'h3468BB, 24'h397DD1,
      24'h4E8BD8, 24'h6398DF, 24'h79A6E5, 24'h8FB3EB, 24'hA6C1F1, 24'hBCD0F7, 24'hD3ECF8,
      24'hDEE2E5, 24'hE8E6D2, 24'hF1E9BF, 24'hF4DF99, 24'hF6D57A, 24'hF8C95F, 24'hFAA741,
      24'hFC8523, 24'hFF6200, 24'hFF8500, 24'hFF9300, 24'hFFA100, 24'hFFAA00, 24'hDA9000,
      24'hCC8000, 24'hB57100, 24'hA05F01, 24'h995700, 24'h8A4D03, 24'h7C4302, 24'h703B03,
      24'h653403, 24'h5C2C05, 24'h532506, 24'h4A1F07, 24'h42200F, 24'h3B1B10
   };

   // One point in flight through the iteration chain
   typedef struct packed {
      logic                          valid;
      logic                          done;
      logic                          in_set;
      logic [INDEX_WIDTH-1:0]        palette_index;
      logic signed [COORD_WIDTH-1:0] re;
      logic signed [COORD_WIDTH-1:0] im;
   } point_type;

   // Clamp a wide signed sum to the signed 32-bit coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [WIDE_WIDTH-1:0] value);
      logic signed [COORD_WIDTH-1:0] result;
      if (value > COORD_MAX) begin
         result = COORD_MAX[COORD_WIDTH-1:0];
      end else if (value < COORD_MIN) begin
         result = COORD_MIN[COORD_WIDTH-1:0];
      end else begin
         result = value[COORD_WIDTH-1:0];
      end
      return result;
   endfunction

   function automatic logic [COLOR_WIDTH-1:0] palette_color(
      input logic [INDEX_WIDTH-1:0] index);
      logic [COLOR_WIDTH-1:0] color;
      if (32'(index) < PALETTE_SIZE) begin
         color = PALETTE_ROM[index];
      end else begin
         color = INSIDE_COLOR;
      end
      return color;
   endfunction

endpackage

@@ sv/julia_escape_time_pixel_unit.sv @@
// Throughput: one pixel per cycle unless the response stalls; every iteration has its own
// three-stage unit, so the unrolled chain of ITERATION_STAGES+1 units sets the latency,
// not the rate.
// A stalled response freezes the whole pipeline for that cycle; nothing is dropped.
// Reset (synchronous, active high) clears all valid bits and loads the register
// defaults; no clearing pass is needed.
module julia_escape_time_pixel_unit #(
   parameter int ITERATION_STAGES = jetp_pkg::ITERATION_STAGES_DEFAULT,
   parameter int FRACTION_BITS    = jetp_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_write,
   input  logic [jetp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [jetp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   // pixel request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [jetp_pkg::PIXEL_WIDTH-1:0]      req_pixel_x,
   input  logic [jetp_pkg::PIXEL_WIDTH-1:0]      req_pixel_y,
   // color response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [jetp_pkg::COLOR_WIDTH-1:0]      rsp_pixel_color,
   output logic                                  rsp_is_inside,
   output logic [jetp_pkg::INDEX_WIDTH-1:0]      rsp_palette_index
);
   import jetp_pkg::*;

   localparam int LIMIT_WIDTH = $clog2(ITERATION_STAGES + 1);
   localparam int PROD_WIDTH  = PIXEL_WIDTH + STEP_WIDTH;
   localparam int UNIT_COUNT  = ITERATION_STAGES + 1;

   // ------------------------------------------------------------------
   // Configuration registers. Write only while the pipe is idle; the block does not check it.
   // ------------------------------------------------------------------
   logic signed [COORD_WIDTH-1:0] x_origin_ff;
   logic signed [COORD_WIDTH-1:0] y_origin_ff;
   logic [STEP_WIDTH-1:0]         x_step_ff;
   logic [STEP_WIDTH-1:0]         y_step_ff;
   logic signed [COORD_WIDTH-1:0] c_real_ff;
   logic signed [COORD_WIDTH-1:0] c_imag_ff;
   logic [ITER_WIDTH-1:0]         max_iter_ff;
   logic [LIMIT_WIDTH-1:0]        limit_ff, limit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff <= X_ORIGIN_RESET;
         y_origin_ff <= Y_ORIGIN_RESET;
         x_step_ff   <= X_STEP_RESET;
         y_step_ff   <= Y_STEP_RESET;
         c_real_ff   <= C_REAL_RESET;
         c_imag_ff   <= C_IMAG_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_X_ORIGIN: x_origin_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_Y_ORIGIN: y_origin_ff <= csr_wdata[COORD_WIDTH-1:0];
            CSR_X_STEP:   x_step_ff   <= csr_wdata[STEP_WIDTH-1:0];
            CSR_Y_STEP:   y_step_ff   <= csr_wdata[STEP_WIDTH-1:0];
            CSR_C_REAL:   c_real_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_C_IMAG:   c_imag_ff   <= csr_wdata[COORD_WIDTH-1:0];
            CSR_MAX_ITER: max_iter_ff <= csr_wdata[ITER_WIDTH-1:0];
            default: begin
               // drop writes beyond the register map
            end
         endcase
      end
   end

   // Clamp the limit to the number of unrolled iterations; register it so the
   // compare in every unit sees a flop.
   always_comb begin
      if (32'(max_iter_ff) > ITERATION_STAGES) begin
         limit_in = LIMIT_WIDTH'(ITERATION_STAGES);
      end else begin
         limit_in = LIMIT_WIDTH'(max_iter_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_WIDTH'(ITERATION_STAGES);
      end else begin
         limit_ff <= limit_in;
      end
   end

   // ------------------------------------------------------------------
   // Flow control: one global enable. Advance the whole pipe unless the
   // response register holds a transaction that the sink stalls.
   // ------------------------------------------------------------------
   logic advance;
   logic rsp_valid_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   // ------------------------------------------------------------------
   // Mapping stage 1: pixel index times step (unsigned 10 x 31).
   // ------------------------------------------------------------------
   logic                  valid_m1_ff;
   logic [PROD_WIDTH-1:0] prod_x_m1_ff, prod_x_m1_in;
   logic [PROD_WIDTH-1:0] prod_y_m1_ff, prod_y_m1_in;

   assign prod_x_m1_in = PROD_WIDTH'(req_pixel_x) * PROD_WIDTH'(x_step_ff);
   assign prod_y_m1_in = PROD_WIDTH'(req_pixel_y) * PROD_WIDTH'(y_step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_m1_ff <= 1'b0;
      end else if (advance) begin
         valid_m1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_m1_ff <= prod_x_m1_in;
         prod_y_m1_ff <= prod_y_m1_in;
      end
   end

   // ------------------------------------------------------------------
   // Mapping stage 2: add origin and clamp to form the start point z0.
   // ------------------------------------------------------------------
   point_type point_m2_ff, point_m2_in;

   always_comb begin
      point_m2_in.valid         = valid_m1_ff;
      point_m2_in.done          = 1'b0;
      point_m2_in.in_set        = 1'b0;
      point_m2_in.palette_index = '0;
      point_m2_in.re = sat_coord(WIDE_WIDTH'(x_origin_ff) +
                                 WIDE_WIDTH'($signed({1'b0, prod_x_m1_ff})));
      point_m2_in.im = sat_coord(WIDE_WIDTH'(y_origin_ff) +
                                 WIDE_WIDTH'($signed({1'b0, prod_y_m1_ff})));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_m2_ff.valid <= 1'b0;
      end else if (advance) begin
         point_m2_ff <= point_m2_in;
      end
   end

   // ------------------------------------------------------------------
   // Iteration chain. Unit k tests z_k and computes z_(k+1); a point that
   // escapes or reaches the limit is marked done and rides along with that decision.
   // The last unit only contributes its test: any point still running there
   // escapes, or else has reached the limit and is marked inside.
   // ------------------------------------------------------------------
   point_type chain [UNIT_COUNT + 1];

   assign chain[0] = point_m2_ff;

   for (genvar k = 0; k < UNIT_COUNT; k++) begin : g_iter
      jetp_iter_unit #(
         .UNIT_INDEX    (k),
         .FRACTION_BITS (FRACTION_BITS),
         .LIMIT_WIDTH   (LIMIT_WIDTH)
      ) u_iter (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .limit     (limit_ff),
         .c_real    (c_real_ff),
         .c_imag    (c_imag_ff),
         .point_in  (chain[k]),
         .point_out (chain[k + 1])
      );
   end

   // ------------------------------------------------------------------
   // Response register: palette lookup, black for inside points.
   // ------------------------------------------------------------------
   point_type              last_point;
   logic [COLOR_WIDTH-1:0] rsp_pixel_color_ff, rsp_pixel_color_in;
   logic                   rsp_is_inside_ff;
   logic [INDEX_WIDTH-1:0] rsp_palette_index_ff;

   assign last_point = chain[UNIT_COUNT];
   assign rsp_pixel_color_in = last_point.in_set ? INSIDE_COLOR :
                               palette_color(last_point.palette_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= last_point.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pixel_color_ff   <= rsp_pixel_color_in;
         rsp_is_inside_ff     <= last_point.in_set;
         rsp_palette_index_ff <= last_point.palette_index;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_color   = rsp_pixel_color_ff;
   assign rsp_is_inside     = rsp_is_inside_ff;
   assign rsp_palette_index = rsp_palette_index_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_inside_black : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_inside |->
         rsp_pixel_color == INSIDE_COLOR && rsp_palette_index == '0)
      else $error("inside pixel not reported black with index zero");

   a_escape_color : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_inside |->
         32'(rsp_palette_index) < PALETTE_MODULUS &&
         rsp_pixel_color == palette_color(rsp_palette_index))
      else $error("escaped pixel color does not match its palette index");

   a_chain_done : assert property (@(posedge clock) disable iff (reset)
      last_point.valid |-> last_point.done)
      else $error("point left the iteration chain without a decision");

   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

@@ sv/jetp_iter_unit.sv @@
// One escape-time iteration: radius test on z and the step z*z + c, in three stages.
// Depends on jetp_pkg for the point struct and the saturation helper.
module jetp_iter_unit #(
   parameter int UNIT_INDEX    = 0,
   parameter int FRACTION_BITS = jetp_pkg::FRACTION_BITS_DEFAULT,
   parameter int LIMIT_WIDTH   = 7
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic [LIMIT_WIDTH-1:0]                  limit,
   input  logic signed [jetp_pkg::COORD_WIDTH-1:0] c_real,
   input  logic signed [jetp_pkg::COORD_WIDTH-1:0] c_imag,
   input  jetp_pkg::point_type                     point_in,
   output jetp_pkg::point_type                     point_out
);
   import jetp_pkg::*;

   localparam int PROD_WIDTH = 2 * COORD_WIDTH;
   localparam int SUM_WIDTH  = (2 * FRACTION_BITS + 3 > PROD_WIDTH + 1) ?
                               2 * FRACTION_BITS + 3 : PROD_WIDTH + 1;
   localparam logic [SUM_WIDTH-1:0] RADIUS_SQ = SUM_WIDTH'(1) << (2 * FRACTION_BITS + 2);
   localparam logic [INDEX_WIDTH-1:0] ESCAPE_INDEX =
      INDEX_WIDTH'(UNIT_INDEX % PALETTE_MODULUS);
   localparam logic [LIMIT_WIDTH-1:0] UNIT_COUNT = LIMIT_WIDTH'(UNIT_INDEX);

   // Stage A: products
   logic signed [COORD_WIDTH-1:0] re_in;
   logic signed [COORD_WIDTH-1:0] im_in;
   point_type                     point_a_ff;
   logic signed [PROD_WIDTH-1:0]  sq_re_a_ff, sq_re_a_in;
   logic signed [PROD_WIDTH-1:0]  sq_im_a_ff, sq_im_a_in;
   logic signed [PROD_WIDTH-1:0]  cross_a_ff, cross_a_in;

   assign re_in      = point_in.re;
   assign im_in      = point_in.im;
   assign sq_re_a_in = PROD_WIDTH'(re_in) * PROD_WIDTH'(re_in);
   assign sq_im_a_in = PROD_WIDTH'(im_in) * PROD_WIDTH'(im_in);
   assign cross_a_in = PROD_WIDTH'(re_in) * PROD_WIDTH'(im_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         point_a_ff.valid <= 1'b0;
      end else if (advance) begin
         point_a_ff <= point_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_re_a_ff <= sq_re_a_in;
         sq_im_a_ff <= sq_im_a_in;
         cross_a_ff <= cross_a_in;
      end
   end

   // Stage B: radius test, decision, scaled real and imaginary parts
   logic [SUM_WIDTH-1:0]          radius_b;
   logic                          within_b;
   logic signed [PROD_WIDTH-1:0]  diff_b;
   point_type                     point_b_ff, point_b_in;
   logic signed [PROD_WIDTH-1:0]  re_raw_b_ff, re_raw_b_in;
   logic signed [PROD_WIDTH-1:0]  im_raw_b_ff, im_raw_b_in;

   assign radius_b    = SUM_WIDTH'($unsigned(sq_re_a_ff)) + SUM_WIDTH'($unsigned(sq_im_a_ff));
   assign within_b    = radius_b <= RADIUS_SQ;
   assign diff_b      = sq_re_a_ff - sq_im_a_ff;
   assign re_raw_b_in = diff_b >>> FRACTION_BITS;
   assign im_raw_b_in = cross_a_ff >>> (FRACTION_BITS - 1);

   always_comb begin
      point_b_in = point_a_ff;
      if (!point_a_ff.done) begin
         if (!within_b) begin
            point_b_in.done          = 1'b1;
            point_b_in.in_set        = 1'b0;
            point_b_in.palette_index = ESCAPE_INDEX;
         end else if (UNIT_COUNT >= limit) begin
            point_b_in.done          = 1'b1;
            point_b_in.in_set        = 1'b1;
            point_b_in.palette_index = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_b_ff.valid <= 1'b0;
      end else if (advance) begin
         point_b_ff <= point_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         re_raw_b_ff <= re_raw_b_in;
         im_raw_b_ff <= im_raw_b_in;
      end
   end

   // Stage C: add c and clamp
   point_type point_c_ff, point_c_in;

   always_comb begin
      point_c_in    = point_b_ff;
      point_c_in.re = sat_coord(WIDE_WIDTH'(re_raw_b_ff) + WIDE_WIDTH'(c_real));
      point_c_in.im = sat_coord(WIDE_WIDTH'(im_raw_b_ff) + WIDE_WIDTH'(c_imag));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_c_ff.valid <= 1'b0;
      end else if (advance) begin
         point_c_ff <= point_c_in;
      end
   end

   assign point_out = point_c_ff;

endmodule

@@ sim/julia_escape_time_pixel_unit_tb.sv @@
// Self-checking testbench for julia_escape_time_pixel_unit: pixel coordinates in, colors out.
// Carries its own escape-time predictor and palette; uses jetp_pkg for widths and CSR indexes.
`timescale 1ns / 1ps

module julia_escape_time_pixel_unit_tb;
   import jetp_pkg::*;

   localparam int ITERATION_STAGES = ITERATION_STAGES_DEFAULT;
   localparam int FRACTION_BITS    = FRACTION_BITS_DEFAULT;
   localparam int PIPE_LATENCY     = 3 * ITERATION_STAGES + 6;
   localparam int RUN_LIMIT        = 500000;
   localparam int RANDOM_PHASES    = 12;
   localparam int PHASE_PIXELS     = 160;
   localparam int COLOR_CYCLE      = 50;

   // index past the end of the register map; writes to it must change nothing
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NO_REG = 3'd7;

   // |z|^2 <= 4 in Q8.56
   localparam longint unsigned ESCAPE_RADIUS_SQ = 64'd4 << (2 * FRACTION_BITS);

   // escape colors for counts 0..49
   localparam logic [COLOR_WIDTH-1:0] SHADE_LUT [COLOR_CYCLE] = '{
      24'h2C1014, 24'h251016, 24'h1F1118, 24'h191119, 24'h140F1A, 24'h100D26, 24'h0D0A2D,
      24'h0A0733, 24'h07053A, 24'h040249, 24'h020352, 24'h01055C, 24'h000766, 24'h06227E,
      24'h0C2C8A, 24'h11388C, 24'h18459C, 24'h1F52B1, 24'h2A60B7, 24'h3468BB, 24'h397DD1,
      24'h4E8BD8, 24'h6398DF, 24'h79A6E5, 24'h8FB3EB, 24'hA6C1F1, 24'hBCD0F7, 24'hD3ECF8,
      24'hDEE2E5, 24'hE8E6D2, 24'hF1E9BF, 24'hF4DF99, 24'hF6D57A, 24'hF8C95F, 24'hFAA741,
      24'hFC8523, 24'hFF6200, 24'hFF8500, 24'hFF9300, 24'hFFA100, 24'hFFAA00, 24'hDA9000,
      24'hCC8000, 24'hB57100, 24'hA05F01, 24'h995700, 24'h8A4D03, 24'h7C4302, 24'h703B03,
      24'h653403
   };

   // well-known Julia constants in Q4.28; they give boundaries with long escape times
   localparam int JULIA_RE [6] = '{-214748365, 76504105, -107374182, -188377266,
                                   95294587, -224143606};
   localparam int JULIA_IM [6] = '{41875931, 2684355, 161061274, -103132902,
                                   95294587, -62303869};

   typedef struct {
      logic [PIXEL_WIDTH-1:0] x;
      logic [PIXEL_WIDTH-1:0] y;
      bit                     hold_off;   // wait for an empty pipeline before sending
   } pixel_req_type;

   typedef struct {
      logic [COLOR_WIDTH-1:0] color;
      logic                   in_set;
      logic [INDEX_WIDTH-1:0] index;
   } pixel_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_write = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [PIXEL_WIDTH-1:0]     req_pixel_x = '0;
   logic [PIXEL_WIDTH-1:0]     req_pixel_y = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [COLOR_WIDTH-1:0]     rsp_pixel_color;
   logic                       rsp_is_inside;
   logic [INDEX_WIDTH-1:0]     rsp_palette_index;

   // shadow copy of the register file
   logic signed [COORD_WIDTH-1:0] win_x0   = X_ORIGIN_RESET;
   logic signed [COORD_WIDTH-1:0] win_y0   = Y_ORIGIN_RESET;
   logic [STEP_WIDTH-1:0]         win_dx   = X_STEP_RESET;
   logic [STEP_WIDTH-1:0]         win_dy   = Y_STEP_RESET;
   logic signed [COORD_WIDTH-1:0] julia_cr = C_REAL_RESET;
   logic signed [COORD_WIDTH-1:0] julia_ci = C_IMAG_RESET;
   logic [ITER_WIDTH-1:0]         iter_cap = MAX_ITER_RESET;

   pixel_req_type pixel_in_q [$];    // coordinates waiting to be sent
   pixel_rsp_type pixel_out_q [$];   // predicted colors, oldest first

   int send_idle_pct = 7;
   int recv_idle_pct = 74;
   int errors        = 0;
   int cycle_count   = 0;

   julia_escape_time_pixel_unit #(
      .ITERATION_STAGES (ITERATION_STAGES),
      .FRACTION_BITS    (FRACTION_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_is_inside     (rsp_is_inside),
      .rsp_palette_index (rsp_palette_index)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Clamp to the signed 32-bit coordinate range
   function automatic longint clamp_coord(input longint v);
      if (v > 64'sh0000_0000_7FFF_FFFF) return 64'sh0000_0000_7FFF_FFFF;
      if (v < -64'sh0000_0000_8000_0000) return -64'sh0000_0000_8000_0000;
      return v;
   endfunction

   // Escape-time color of one pixel under the current shadow registers
   function automatic pixel_rsp_type color_of_pixel(input logic [PIXEL_WIDTH-1:0] px,
                                                    input logic [PIXEL_WIDTH-1:0] py);
      longint          col, row, x0, y0, dx, dy, cr, ci;
      longint          re, im, nre, nim;
      longint unsigned ar, ai;
      int              limit, count;
      bit              in_set;
      pixel_rsp_type   r;
      col = px;
      row = py;
      x0  = win_x0;
      y0  = win_y0;
      dx  = win_dx;
      dy  = win_dy;
      cr  = julia_cr;
      ci  = julia_ci;
      re  = clamp_coord(x0 + col * dx);
      im  = clamp_coord(y0 + row * dy);
      // a limit beyond the unrolled chain behaves as the chain length
      limit  = (int'(iter_cap) > ITERATION_STAGES) ? ITERATION_STAGES : int'(iter_cap);
      count  = 0;
      in_set = 1'b0;
      while (1) begin
         ar = (re < 0) ? -re : re;
         ai = (im < 0) ? -im : im;
         if (ar * ar + ai * ai > ESCAPE_RADIUS_SQ) break;
         if (count >= limit) begin
            in_set = 1'b1;
            break;
         end
         // arithmetic shift rounds toward minus infinity
         nre = clamp_coord(((re * re - im * im) >>> FRACTION_BITS) + cr);
         nim = clamp_coord(((re * im) >>> (FRACTION_BITS - 1)) + ci);
         re  = nre;
         im  = nim;
         count++;
      end
      if (in_set) begin
         r.color  = INSIDE_COLOR;
         r.in_set = 1'b1;
         r.index  = '0;
      end else begin
         r.index  = INDEX_WIDTH'(count % COLOR_CYCLE);
         r.color  = SHADE_LUT[count % COLOR_CYCLE];
         r.in_set = 1'b0;
      end
      return r;
   endfunction

   // Driver: when the request slot frees up, present the next pending pixel or idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // record the prediction the moment the transaction is taken
         if (req_valid && !req_stall) begin
            pixel_out_q.push_back(color_of_pixel(req_pixel_x, req_pixel_y));
         end
         // hold a stalled transaction; otherwise load the next one or idle
         if (!req_valid || !req_stall) begin
            if (pixel_in_q.size() != 0 &&
                !(pixel_in_q[0].hold_off && pixel_out_q.size() != 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_pixel_x <= pixel_in_q[0].x;
               req_pixel_y <= pixel_in_q[0].y;
               void'(pixel_in_q.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted response against the oldest prediction.
   always @(posedge clock) begin : response_check
      pixel_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pixel_out_q.size() == 0) begin
               $error("response with no pixel outstanding: color %h", rsp_pixel_color);
               errors++;
            end else begin
               want = pixel_out_q.pop_front();
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color mismatch: expected %h, actual %h",
                         want.color, rsp_pixel_color);
                  errors++;
               end
               if (rsp_is_inside !== want.in_set) begin
                  $error("is_inside mismatch: expected %b, actual %b",
                         want.in_set, rsp_is_inside);
                  errors++;
               end
               if (rsp_palette_index !== want.index) begin
                  $error("palette_index mismatch: expected %0d, actual %0d",
                         want.index, rsp_palette_index);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("julia_escape_time_pixel_unit_tb failed");
         $finish;
      end
   end

   task automatic queue_pixel(input logic [PIXEL_WIDTH-1:0] x,
                              input logic [PIXEL_WIDTH-1:0] y,
                              input bit hold_off = 1'b0);
      pixel_in_q.push_back('{x: x, y: y, hold_off: hold_off});
   endtask

   // Wait until every pixel has been sent and every color has come back;
   // look between edges so that the driver and monitor have settled
   task automatic drain_pipeline();
      while (pixel_in_q.size() != 0 || req_valid || pixel_out_q.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // One register write; mirror it into the shadow copy with the same masking
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_X_ORIGIN: win_x0   = data;
         CSR_Y_ORIGIN: win_y0   = data;
         CSR_X_STEP:   win_dx   = data[STEP_WIDTH-1:0];
         CSR_Y_STEP:   win_dy   = data[STEP_WIDTH-1:0];
         CSR_C_REAL:   julia_cr = data;
         CSR_C_IMAG:   julia_ci = data;
         CSR_MAX_ITER: iter_cap = data[ITER_WIDTH-1:0];
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all(input logic [31:0] x0, input logic [31:0] y0,
                            input logic [31:0] dx, input logic [31:0] dy,
                            input logic [31:0] cr, input logic [31:0] ci,
                            input logic [31:0] cap);
      write_reg(CSR_X_ORIGIN, x0);
      write_reg(CSR_Y_ORIGIN, y0);
      write_reg(CSR_X_STEP, dx);
      write_reg(CSR_Y_STEP, dy);
      write_reg(CSR_C_REAL, cr);
      write_reg(CSR_C_IMAG, ci);
      write_reg(CSR_MAX_ITER, cap);
      end_writes();
   endtask

   // Pick a window for one random phase: mostly a frame around a known Julia set,
   // sometimes raw register noise; unused high bits carry junk
   task automatic pick_window();
      int          sel, k, step_x, step_y, jit;
      logic [31:0] cap;
      sel    = $urandom_range(7);
      k      = $urandom_range(5);
      step_x = $urandom_range(1000000, 200000);
      step_y = $urandom_range(1000000, 200000);
      jit    = int'($urandom_range(1 << 24)) - (1 << 23);
      case ($urandom_range(9))
         0:       cap = 32'd0;
         1:       cap = $urandom_range(127, 65);
         default: cap = $urandom_range(64, 1);
      endcase
      cap[31:ITER_WIDTH] = (32 - ITER_WIDTH)'($urandom());
      if (sel == 0) begin
         write_all($urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
      end else begin
         write_all(-(step_x * 512) + jit, -(step_y * 512) - jit,
                   {1'($urandom_range(1)), 31'(step_x)},
                   {1'($urandom_range(1)), 31'(step_y)},
                   JULIA_RE[k] + (jit >>> 4), JULIA_IM[k] - (jit >>> 4), cap);
      end
   endtask

   initial begin : stimulus
      int p, i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset defaults: corners, points on the axes, and a few others
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      queue_pixel(0, 1023);
      queue_pixel(1023, 0);
      queue_pixel(128, 128);
      queue_pixel(1, 1);
      queue_pixel(512, 0);
      queue_pixel(384, 512);
      drain_pipeline();

      // zero limit: inside at once within radius 2; the corners both escape with count 0
      write_reg(CSR_MAX_ITER, 32'd0);
      end_writes();
      queue_pixel(0, 0);
      queue_pixel(1023, 1023);
      drain_pipeline();

      // limit above the chain length, classic Julia frame, all-ones write data
      write_all(-429496730, -429496730, 838861, 838861,
                JULIA_RE[0], JULIA_IM[0], 32'hFFFF_FFFF);
      queue_pixel(512, 512);
      queue_pixel(600, 480);
      queue_pixel(300, 700);
      queue_pixel(0, 0);
      drain_pipeline();

      // register extremes: start point and step sums saturate; a stray index is ignored
      write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'd64);
      write_reg(CSR_NO_REG, 32'hFFFF_FFFF);
      end_writes();
      queue_pixel(1023, 1023);
      queue_pixel(0, 0);
      queue_pixel(1, 0);
      drain_pipeline();

      // all zero registers except a limit of one: every pixel sits at z = 0
      write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
      queue_pixel(1023, 0);
      queue_pixel(0, 1023);
      drain_pipeline();

      // exactly on the radius-2 circle, then just inside it
      write_all(-536870912, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd3);
      queue_pixel(0, 0);
      queue_pixel(1, 0);
      drain_pipeline();

      // --- random part ---
      for (p = 0; p < RANDOM_PHASES; p++) begin
         // sender rarely idles, then receiver rarely stalls, then no idling at all
         if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 7;
            recv_idle_pct = 74;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 74;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         pick_window();
         for (i = 0; i < PHASE_PIXELS; i++) begin
            // now and then hold the next transaction until the pipeline has emptied
            queue_pixel(PIXEL_WIDTH'($urandom_range(1023)), PIXEL_WIDTH'($urandom_range(1023)),
                        (i == 60) && (p % 4 == 1));
         end
         drain_pipeline();
      end

      // let any stray response surface before the verdict
      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (pixel_out_q.size() != 0) begin
         $error("%0d predicted colors never arrived", pixel_out_q.size());
         errors++;
      end
      if (errors == 0) begin
         $display("julia_escape_time_pixel_unit_tb passed");
      end else begin
         $display("julia_escape_time_pixel_unit_tb failed");
      end
      $finish;
   end

endmodule

@@ julia_escape_time_pixel_unit.f @@
sv/jetp_pkg.sv
sv/jetp_iter_unit.sv
sv/julia_escape_time_pixel_unit.sv
sim/julia_escape_time_pixel_unit_tb.sv
